// ----- rtl/fpalu_pkg.sv -----
// shared types and constants of the fixed-point alu
`default_nettype none
package fpalu_pkg;

  localparam int unsigned FracBitsDefault = 8;
  localparam int unsigned DataW           = 32;

  typedef enum logic [3:0] {
    FUNC_ADD      = 4'd0,
    FUNC_SUB      = 4'd1,
    FUNC_MUL      = 4'd2,
    FUNC_DIV      = 4'd3,
    FUNC_GT       = 4'd4,
    FUNC_LT       = 4'd5,
    FUNC_GE       = 4'd6,
    FUNC_LE       = 4'd7,
    FUNC_EQ       = 4'd8,
    FUNC_NE       = 4'd9,
    FUNC_MIN      = 4'd10,
    FUNC_MAX      = 4'd11,
    FUNC_INC      = 4'd12,
    FUNC_DEC      = 4'd13,
    FUNC_FROM_INT = 4'd14,
    FUNC_TO_INT   = 4'd15
  } func_e;

endpackage
`default_nettype wire

// ----- rtl/fixed_point_alu_unit.sv -----
// fixed-point alu top level: pipelined signed arithmetic, compare and divide
`default_nettype none
// signed fixed-point alu on 32-bit raw values with FracBits fraction bits. one
// result request leaves for every request taken, in order. the block is a
// single pipeline of 32 + FracBits + 3 register stages (43 at the default of
// 8); every operation walks the full depth so that order is kept for free. the
// depth is set by the divider, which retires one quotient bit per stage
// (restoring division of |a| << FracBits by |b|). a new request can be taken
// every cycle; a stall on the result side only holds the stages that are
// full, so bubbles inside the pipe close up. multiply uses one 32x32 signed
// multiplier followed by a registered round-toward-zero bias and a shift.
// divide by zero returns zero with div_by_zero set.
module fixed_point_alu_unit #(
  parameter int unsigned FracBits = fpalu_pkg::FracBitsDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  // func [3:0], operand_a [35:4], operand_b [67:36], zero fill [71:68]
  input  wire logic [71:0] s_axis_tdata_i,
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  // result [31:0], is_true [32], div_by_zero [33], zero fill [39:34]
  output logic [39:0]      m_axis_tdata_o
);

  localparam int unsigned DataW  = fpalu_pkg::DataW;
  // dividend and quotient width of the divider
  localparam int unsigned DivW   = DataW + FracBits;
  // input stage, prep stage, DivW divide stages, final stage
  localparam int unsigned Stages = DivW + 3;
  localparam int unsigned LastSt = Stages - 1;

  typedef struct packed {
    fpalu_pkg::func_e          func;
    logic signed [DataW-1:0]   a;
    logic signed [DataW-1:0]   b;
    logic [DataW-1:0]          res;     // simple result, later the final one
    logic                      flag;
    logic                      dz;
    logic                      neg;     // sign of the quotient
    logic signed [2*DataW-1:0] prod;
    logic [DataW-1:0]          dvsr;
    logic [DataW-1:0]          rem;
    logic [DivW-1:0]           dq;      // dividend shifting out, quotient in
  } stage_t;

  stage_t             stg_q [Stages];
  stage_t             stg_d [Stages];
  logic [Stages-1:0]  vld_q;
  logic [Stages-1:0]  vld_d;
  logic [Stages-1:0]  adv;

  // prep stage: all results but multiply and divide, multiplier and divider setup
  function automatic stage_t prep(stage_t s);
    stage_t                  o;
    logic [DataW-1:0]        abs_a;
    logic [DataW-1:0]        abs_b;
    o     = s;
    abs_a = s.a[DataW-1] ? DataW'(-s.a) : DataW'(s.a);
    abs_b = s.b[DataW-1] ? DataW'(-s.b) : DataW'(s.b);
    o.res  = '0;
    o.flag = 1'b0;
    o.dz   = (s.func == fpalu_pkg::FUNC_DIV) && (s.b == '0);
    o.neg  = s.a[DataW-1] ^ s.b[DataW-1];
    o.prod = (2*DataW)'(s.a) * (2*DataW)'(s.b);
    o.dvsr = abs_b;
    o.rem  = '0;
    o.dq   = DivW'(abs_a) << FracBits;
    unique case (s.func)
      fpalu_pkg::FUNC_ADD:      o.res = DataW'(s.a + s.b);
      fpalu_pkg::FUNC_SUB:      o.res = DataW'(s.a - s.b);
      fpalu_pkg::FUNC_GT:       o.flag = (s.a > s.b);
      fpalu_pkg::FUNC_LT:       o.flag = (s.a < s.b);
      fpalu_pkg::FUNC_GE:       o.flag = (s.a >= s.b);
      fpalu_pkg::FUNC_LE:       o.flag = (s.a <= s.b);
      fpalu_pkg::FUNC_EQ:       o.flag = (s.a == s.b);
      fpalu_pkg::FUNC_NE:       o.flag = (s.a != s.b);
      fpalu_pkg::FUNC_MIN:      o.res = (s.a < s.b) ? s.a : s.b;
      fpalu_pkg::FUNC_MAX:      o.res = (s.a > s.b) ? s.a : s.b;
      fpalu_pkg::FUNC_INC:      o.res = DataW'(s.a + 1);
      fpalu_pkg::FUNC_DEC:      o.res = DataW'(s.a - 1);
      fpalu_pkg::FUNC_FROM_INT: o.res = DataW'(s.a <<< FracBits);
      fpalu_pkg::FUNC_TO_INT:   o.res = DataW'(s.a >>> FracBits);
      default:                  o.res = '0;
    endcase
    return o;
  endfunction

  // one restoring division step
  function automatic stage_t div_step(stage_t s);
    stage_t          o;
    logic [DataW:0]  trial;
    logic            bit_q;
    o     = s;
    trial = {s.rem, s.dq[DivW-1]};
    bit_q = (trial >= {1'b0, s.dvsr});
    o.rem = bit_q ? DataW'(trial - {1'b0, s.dvsr}) : DataW'(trial);
    o.dq  = {s.dq[DivW-2:0], bit_q};
    return o;
  endfunction

  // last stage: pick and fix up the result
  function automatic stage_t finish(stage_t s);
    stage_t o;
    o = s;
    if (s.func == fpalu_pkg::FUNC_DIV) begin
      o.res = s.dz ? '0 : (s.neg ? DataW'(-s.dq[DataW-1:0]) : s.dq[DataW-1:0]);
    end else if (s.func == fpalu_pkg::FUNC_MUL) begin
      o.res = s.prod[FracBits +: DataW];
    end
    return o;
  endfunction

  // bubble-collapsing advance: a stage moves if empty or its successor moves
  always_comb begin
    adv[LastSt] = ~vld_q[LastSt] | m_axis_tready_i;
    for (int k = LastSt - 1; k >= 0; k--) begin
      adv[k] = ~vld_q[k] | adv[k+1];
    end
  end

  assign s_axis_tready_o = adv[0];

  always_comb begin
    stage_t in_s;
    in_s      = '0;
    in_s.func = fpalu_pkg::func_e'(s_axis_tdata_i[3:0]);
    in_s.a    = s_axis_tdata_i[35:4];
    in_s.b    = s_axis_tdata_i[67:36];
    vld_d     = vld_q;
    for (int k = 0; k < Stages; k++) begin
      stg_d[k] = stg_q[k];
    end
    if (adv[0]) begin
      vld_d[0] = s_axis_tvalid_i;
      stg_d[0] = in_s;
    end
    for (int k = 1; k < Stages; k++) begin
      if (adv[k]) begin
        vld_d[k] = vld_q[k-1];
        if (k == 1) begin
          stg_d[k] = prep(stg_q[k-1]);
        end else if (k == LastSt) begin
          stg_d[k] = finish(stg_q[k-1]);
        end else begin
          stg_d[k] = div_step(stg_q[k-1]);
          // round toward zero bias for a negative product, added once
          if (k == 2 && stg_q[k-1].prod[2*DataW-1]) begin
            stg_d[k].prod = stg_q[k-1].prod
                          + $signed((2*DataW)'((65'd1 << FracBits) - 65'd1));
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < Stages; k++) begin
      stg_q[k] <= stg_d[k];
    end
  end

  assign m_axis_tvalid_o = vld_q[LastSt];
  assign m_axis_tdata_o  = {6'd0, stg_q[LastSt].dz, stg_q[LastSt].flag,
                            stg_q[LastSt].res};

`ifndef SYNTHESIS
  // back-pressure reaches the input only when every stage is occupied
  a_full_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> (&vld_q))
    else $error("input stalled with a bubble in the pipeline");

  // a divide-by-zero result carries a zero value
  a_dz_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tdata_o[33]) |-> (m_axis_tdata_o[31:0] == '0))
    else $error("divide by zero with non-zero result");

  // a comparison outcome never comes with a value or an error
  a_cmp_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tdata_o[32])
      |-> (m_axis_tdata_o[31:0] == '0 && !m_axis_tdata_o[33]))
    else $error("comparison result mixed with value");

  // error flag only for a divide
  a_dz_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tdata_o[33])
      |-> (stg_q[LastSt].func == fpalu_pkg::FUNC_DIV))
    else $error("div_by_zero raised outside divide");
`endif

endmodule
`default_nettype wire

// ----- test/fixed_point_alu_unit_chk.sv -----
// checker for the fixed-point alu: watches both streams, predicts and compares
module fixed_point_alu_unit_chk
  import fpalu_pkg::*;
#(
  parameter int unsigned FracBits = FracBitsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  input  logic        s_axis_tready_i,
  input  logic [71:0] s_axis_tdata_i,
  input  logic        m_axis_tvalid_i,
  input  logic        m_axis_tready_i,
  input  logic [39:0] m_axis_tdata_i,
  output int          fail_count_o,
  output int          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic              dz;
    logic              flag;
    logic signed [31:0] value;
  } alu_answer_t;

  alu_answer_t answer_q[$];

  function automatic alu_answer_t compute_answer(logic [71:0] req);
    func_e              op;
    logic signed [31:0] a, b;
    logic signed [63:0] wide;
    alu_answer_t        ans;
    op = func_e'(req[3:0]);
    a = req[35:4];
    b = req[67:36];
    ans = '0;
    case (op)
      FUNC_ADD: ans.value = a + b;
      FUNC_SUB: ans.value = a - b;
      FUNC_MUL: begin
        wide = 64'(a) * 64'(b);
        wide = wide / (64'sd1 <<< FracBits);
        ans.value = wide[31:0];
      end
      FUNC_DIV: begin
        if (b == 0) begin
          ans.dz = 1'b1;
        end else begin
          wide = (64'(a) <<< FracBits) / 64'(b);
          ans.value = wide[31:0];
        end
      end
      FUNC_GT: ans.flag = a > b;
      FUNC_LT: ans.flag = a < b;
      FUNC_GE: ans.flag = a >= b;
      FUNC_LE: ans.flag = a <= b;
      FUNC_EQ: ans.flag = a == b;
      FUNC_NE: ans.flag = a != b;
      FUNC_MIN: ans.value = (a < b) ? a : b;
      FUNC_MAX: ans.value = (a > b) ? a : b;
      FUNC_INC: ans.value = a + 1;
      FUNC_DEC: ans.value = a - 1;
      FUNC_FROM_INT: ans.value = a <<< FracBits;
      default: ans.value = a >>> FracBits;
    endcase
    return ans;
  endfunction

  assign pending_o = answer_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    alu_answer_t want;
    if (!rst_ni) begin
      fail_count_o <= 0;
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        answer_q.push_back(compute_answer(s_axis_tdata_i));
      end
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        if (answer_q.size() == 0) begin
          $error("unexpected result request %h", m_axis_tdata_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = answer_q.pop_front();
          if (m_axis_tdata_i[31:0] !== want.value || m_axis_tdata_i[32] !== want.flag
              || m_axis_tdata_i[33] !== want.dz || m_axis_tdata_i[39:34] !== 6'd0) begin
            if (m_axis_tdata_i[31:0] !== want.value)
              $error("result: expected %h actual %h", want.value, m_axis_tdata_i[31:0]);
            if (m_axis_tdata_i[32] !== want.flag)
              $error("is_true: expected %b actual %b", want.flag, m_axis_tdata_i[32]);
            if (m_axis_tdata_i[33] !== want.dz)
              $error("div_by_zero: expected %b actual %b", want.dz, m_axis_tdata_i[33]);
            if (m_axis_tdata_i[39:34] !== 6'd0)
              $error("zero fill: expected 0 actual %h", m_axis_tdata_i[39:34]);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
    end
  end
endmodule

// ----- test/fixed_point_alu_unit_tb.sv -----
// testbench top for the fixed-point alu: stimulus, idling and verdict
module fixed_point_alu_unit_tb;
  import fpalu_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned Latency       = 43;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [71:0] s_axis_tdata_i = '0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [39:0] m_axis_tdata_o;
  int          fail_count;
  int          pending;
  int          send_idle_pct = 31;
  int          recv_idle_pct = 88;
  int          quiet_cycles = 0;
  int          request_count = 0;

  always #10 clk_i = ~clk_i;

  fixed_point_alu_unit i_dut (
    .clk_i, .rst_ni, .s_axis_tvalid_i, .s_axis_tready_o, .s_axis_tdata_i,
    .m_axis_tvalid_o, .m_axis_tready_i, .m_axis_tdata_o
  );

  fixed_point_alu_unit_chk i_chk (
    .clk_i, .rst_ni, .s_axis_tvalid_i, .s_axis_tready_i(s_axis_tready_o), .s_axis_tdata_i,
    .m_axis_tvalid_i(m_axis_tvalid_o), .m_axis_tready_i, .m_axis_tdata_i(m_axis_tdata_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // receiver stalls at random, one draw per cycle
  always @(posedge clk_i) begin
    m_axis_tready_i <= rst_ni && ($urandom_range(99) >= recv_idle_pct);
  end

  // watchdog on cycles with no request taken on either side
  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)) begin
      quiet_cycles <= 0;
    end else if (rst_ni) begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("[fixed_point_alu_unit] ERROR");
        $finish;
      end
    end
  end

  // operands biased towards edge values so that wrap and sign cases show up
  function automatic logic [31:0] pick_operand();
    case ($urandom_range(7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'($signed($urandom_range(2047)) - 1024);
      3: return 32'h0;
      4: return 32'($urandom_range(1)) ? 32'hffff_ffff : 32'h1;
      default: return $urandom;
    endcase
  endfunction

  // offer one request and hold it until taken
  task automatic send_request(func_e op, logic [31:0] a, logic [31:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {4'd0, b, a, op};
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    request_count++;
  endtask

  task automatic drain();
    s_axis_tvalid_i <= 1'b0;
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic random_phase(int n);
    func_e op;
    logic [31:0] a, b;
    for (int i = 0; i < n; i++) begin
      op = func_e'($urandom_range(15));
      a = pick_operand();
      b = ($urandom_range(9) == 0) ? a : pick_operand();
      // small operands often for divide so quotients stay in range
      if (op == FUNC_DIV && $urandom_range(1)) begin
        a = 32'($signed($urandom_range(65535)) - 32768);
      end
      send_request(op, a, b);
    end
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: every operation, extremes, divide by zero, equal min/max, to_int rounding
    for (int f = 0; f < 16; f++) begin
      send_request(func_e'(f), 32'h8000_0000, 32'h7fff_ffff);
    end
    send_request(FUNC_DIV, 32'h0000_0100, 32'h0);
    send_request(FUNC_DIV, 32'h8000_0000, 32'hffff_ffff);
    send_request(FUNC_MUL, 32'hffff_ff01, 32'h0000_0001);
    send_request(FUNC_MIN, 32'h0000_0005, 32'h0000_0005);
    send_request(FUNC_MAX, 32'hffff_fff0, 32'hffff_fff0);
    send_request(FUNC_TO_INT, 32'hffff_ff01, 32'h0);
    send_request(FUNC_INC, 32'h7fff_ffff, 32'h0);
    send_request(FUNC_DEC, 32'h8000_0000, 32'hffff_ffff);

    // hold off until every expected result is back
    drain();

    random_phase(430);
    drain();
    send_idle_pct = 88;
    recv_idle_pct = 31;
    random_phase(430);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_phase(440);
    drain();
    repeat (Latency + 10) @(posedge clk_i);

    $display("ran %0d requests over all sixteen operations, edge operands and divide by zero",
             request_count);
    $display("idling: sender-heavy, receiver-heavy and back-to-back phases");
    if (fail_count == 0 && pending == 0) begin
      $display("[fixed_point_alu_unit] OK");
    end else begin
      $display("[fixed_point_alu_unit] ERROR");
    end
    $finish;
  end
endmodule
